// File: rtl/alp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audit record line parser package
// Shared types, codes and default limits for the line parser.
// ----------------------------------------------------------------------------
package alp_pkg;

  // Default part length limits (a part keeps at most limit - 1 characters)
  localparam int unsigned TYPE_LEN_MAX_DEF   = 32;
  localparam int unsigned PREFIX_LEN_MAX_DEF = 64;
  localparam int unsigned KEY_LEN_MAX_DEF    = 64;
  localparam int unsigned VALUE_LEN_MAX_DEF  = 256;
  localparam int unsigned FIELDS_MAX_DEF     = 64;

  // Result queue depth; a power of two so the pointers wrap naturally
  localparam int unsigned OUTQ_DEPTH = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [3:0] {
    MODE_HDR    = 4'd0,
    MODE_IGNORE = 4'd1,
    MODE_TYPE   = 4'd2,
    MODE_SEEK   = 4'd3,
    MODE_PREFIX = 4'd4,
    MODE_KSKIP  = 4'd5,
    MODE_KEY    = 4'd6,
    MODE_VALUE  = 4'd7,
    MODE_DONE   = 4'd8
  } alp_mode_e;

  typedef enum logic [2:0] {
    PART_TYPE    = 3'd0,
    PART_PREFIX  = 3'd1,
    PART_KEY     = 3'd2,
    PART_VALUE   = 3'd3,
    PART_REC_END = 3'd4
  } alp_part_e;

  typedef struct packed {
    alp_part_e  part;
    logic       has_char;
    logic [7:0] out_char;
    logic       part_end;
    logic       kept;
    logic [5:0] field_index;
    logic       record_valid;
    logic [6:0] field_total;
    logic       last;
  } alp_item_t;

  // "type=" header pattern
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h74;
      3'd1:    c = 8'h79;
      3'd2:    c = 8'h70;
      3'd3:    c = 8'h65;
      3'd4:    c = CH_EQUAL;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // "msg=" search pattern
  function automatic logic [7:0] msg_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_M;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h67;
      3'd3:    c = CH_EQUAL;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/alp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line parser state machine
// Updates the parse state per accepted character and forms up to two beats.
// ----------------------------------------------------------------------------
module alp_parse #(
  parameter int unsigned TYPE_LEN_MAX   = alp_pkg::TYPE_LEN_MAX_DEF,
  parameter int unsigned PREFIX_LEN_MAX = alp_pkg::PREFIX_LEN_MAX_DEF,
  parameter int unsigned KEY_LEN_MAX    = alp_pkg::KEY_LEN_MAX_DEF,
  parameter int unsigned VALUE_LEN_MAX  = alp_pkg::VALUE_LEN_MAX_DEF,
  parameter int unsigned FIELDS_MAX     = alp_pkg::FIELDS_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              action_i,
  input  logic [7:0]        ch_i,
  output alp_pkg::alp_item_t item0_o,
  output alp_pkg::alp_item_t item1_o,
  output logic [1:0]        n_items_o
);

  localparam logic [8:0] TYPE_LIM   = 9'(TYPE_LEN_MAX - 1);
  localparam logic [8:0] PREFIX_LIM = 9'(PREFIX_LEN_MAX - 1);
  localparam logic [8:0] KEY_LIM    = 9'(KEY_LEN_MAX - 1);
  localparam logic [8:0] VALUE_LIM  = 9'(VALUE_LEN_MAX - 1);
  localparam logic [6:0] FIELDS_LIM = 7'(FIELDS_MAX);

  alp_pkg::alp_mode_e mode_q, mode_d;
  logic [2:0] match_q, match_d;
  logic [7:0] len_q, len_d;
  logic [6:0] fields_q, fields_d;
  logic       valid_q, valid_d;

  logic       eol;
  logic [8:0] lim;
  logic       room;
  logic [7:0] len_inc;
  logic [6:0] fields_inc;
  logic [5:0] fi;

  assign eol        = action_i | (ch_i == alp_pkg::CH_NUL);
  assign len_inc    = len_q + 8'd1;
  assign fields_inc = fields_q + 7'd1;
  assign fi         = fields_q[5:0];

  always_comb begin
    unique case (mode_q)
      alp_pkg::MODE_TYPE:                     lim = TYPE_LIM;
      alp_pkg::MODE_PREFIX:                   lim = PREFIX_LIM;
      alp_pkg::MODE_VALUE:                    lim = VALUE_LIM;
      default:                                lim = KEY_LIM;
    endcase
  end

  assign room = ({1'b0, len_q} < lim);

  // Next state
  always_comb begin
    mode_d   = mode_q;
    match_d  = match_q;
    len_d    = len_q;
    fields_d = fields_q;
    valid_d  = valid_q;
    if (accept_i) begin
      if (eol) begin
        mode_d   = alp_pkg::MODE_HDR;
        match_d  = 3'd0;
        len_d    = 8'd0;
        fields_d = 7'd0;
        valid_d  = 1'b0;
      end else begin
        unique case (mode_q)
          alp_pkg::MODE_HDR: begin
            if (ch_i == alp_pkg::hdr_char(match_q)) begin
              if (match_q == 3'd4) begin
                mode_d  = alp_pkg::MODE_TYPE;
                match_d = 3'd0;
                len_d   = 8'd0;
              end else begin
                match_d = match_q + 3'd1;
              end
            end else begin
              mode_d  = alp_pkg::MODE_IGNORE;
              match_d = 3'd0;
            end
          end
          alp_pkg::MODE_TYPE: begin
            if (ch_i == alp_pkg::CH_SPACE) begin
              mode_d  = alp_pkg::MODE_SEEK;
              match_d = 3'd0;
              len_d   = 8'd0;
            end else if (room) begin
              len_d = len_inc;
            end
          end
          alp_pkg::MODE_SEEK: begin
            if (ch_i == alp_pkg::msg_char(match_q)) begin
              if (match_q == 3'd3) begin
                mode_d  = alp_pkg::MODE_PREFIX;
                match_d = 3'd0;
                len_d   = 8'd0;
              end else begin
                match_d = match_q + 3'd1;
              end
            end else begin
              match_d = (ch_i == alp_pkg::CH_M) ? 3'd1 : 3'd0;
            end
          end
          alp_pkg::MODE_PREFIX: begin
            if (ch_i == alp_pkg::CH_COLON) begin
              valid_d = 1'b1;
              len_d   = 8'd0;
              mode_d  = (fields_q >= FIELDS_LIM) ? alp_pkg::MODE_DONE
                                                 : alp_pkg::MODE_KSKIP;
            end else if (room) begin
              len_d = len_inc;
            end
          end
          alp_pkg::MODE_KSKIP: begin
            if (ch_i == alp_pkg::CH_EQUAL) begin
              len_d  = 8'd0;
              mode_d = alp_pkg::MODE_VALUE;
            end else if (ch_i != alp_pkg::CH_SPACE) begin
              // first key character always fits (limit is at least two)
              len_d  = 8'd1;
              mode_d = alp_pkg::MODE_KEY;
            end
          end
          alp_pkg::MODE_KEY: begin
            if (ch_i == alp_pkg::CH_EQUAL) begin
              mode_d = alp_pkg::MODE_VALUE;
              len_d  = 8'd0;
            end else if (room) begin
              len_d = len_inc;
            end
          end
          alp_pkg::MODE_VALUE: begin
            if (ch_i == alp_pkg::CH_SPACE) begin
              fields_d = fields_inc;
              len_d    = 8'd0;
              mode_d   = (fields_inc >= FIELDS_LIM) ? alp_pkg::MODE_DONE
                                                    : alp_pkg::MODE_KSKIP;
            end else if (room) begin
              len_d = len_inc;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result beats
  always_comb begin
    item0_o   = '0;
    item1_o   = '0;
    n_items_o = 2'd0;
    if (eol) begin
      item1_o.part         = alp_pkg::PART_REC_END;
      item1_o.record_valid = valid_q;
      item1_o.field_total  = (mode_q == alp_pkg::MODE_VALUE) ? fields_inc : fields_q;
      item1_o.last         = 1'b1;
      n_items_o            = 2'd2;
      item0_o.part_end     = 1'b1;
      unique case (mode_q)
        alp_pkg::MODE_TYPE:   item0_o.part = alp_pkg::PART_TYPE;
        alp_pkg::MODE_PREFIX: item0_o.part = alp_pkg::PART_PREFIX;
        alp_pkg::MODE_KEY: begin
          item0_o.part        = alp_pkg::PART_KEY;
          item0_o.field_index = fi;
        end
        alp_pkg::MODE_VALUE: begin
          item0_o.part        = alp_pkg::PART_VALUE;
          item0_o.field_index = fi;
          item0_o.kept        = 1'b1;
        end
        default: begin
          // no open part: the record end is the only beat
          item0_o   = item1_o;
          n_items_o = 2'd1;
        end
      endcase
    end else begin
      item0_o.last = 1'b1;
      unique case (mode_q) inside
        alp_pkg::MODE_TYPE: begin
          item0_o.part = alp_pkg::PART_TYPE;
          if (ch_i == alp_pkg::CH_SPACE) begin
            item0_o.part_end = 1'b1;
            item0_o.kept     = 1'b1;
            n_items_o        = 2'd1;
          end else if (room) begin
            item0_o.has_char = 1'b1;
            item0_o.out_char = ch_i;
            n_items_o        = 2'd1;
          end
        end
        alp_pkg::MODE_PREFIX: begin
          item0_o.part = alp_pkg::PART_PREFIX;
          if (room) begin
            item0_o.has_char = 1'b1;
            item0_o.out_char = ch_i;
            n_items_o        = 2'd1;
          end
          if (ch_i == alp_pkg::CH_COLON) begin
            item0_o.part_end = 1'b1;
            item0_o.kept     = 1'b1;
            n_items_o        = 2'd1;
          end
        end
        alp_pkg::MODE_KSKIP, alp_pkg::MODE_KEY: begin
          item0_o.part        = alp_pkg::PART_KEY;
          item0_o.field_index = fi;
          if (ch_i == alp_pkg::CH_EQUAL) begin
            item0_o.part_end = 1'b1;
            item0_o.kept     = 1'b1;
            n_items_o        = 2'd1;
          end else if (mode_q == alp_pkg::MODE_KSKIP) begin
            if (ch_i != alp_pkg::CH_SPACE) begin
              item0_o.has_char = 1'b1;
              item0_o.out_char = ch_i;
              n_items_o        = 2'd1;
            end
          end else if (room) begin
            item0_o.has_char = 1'b1;
            item0_o.out_char = ch_i;
            n_items_o        = 2'd1;
          end
        end
        alp_pkg::MODE_VALUE: begin
          item0_o.part        = alp_pkg::PART_VALUE;
          item0_o.field_index = fi;
          if (ch_i == alp_pkg::CH_SPACE) begin
            item0_o.part_end = 1'b1;
            item0_o.kept     = 1'b1;
            n_items_o        = 2'd1;
          end else if (room) begin
            item0_o.has_char = 1'b1;
            item0_o.out_char = ch_i;
            n_items_o        = 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= alp_pkg::MODE_HDR;
      match_q  <= 3'd0;
      len_q    <= 8'd0;
      fields_q <= 7'd0;
      valid_q  <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      match_q  <= match_d;
      len_q    <= len_d;
      fields_q <= fields_d;
      valid_q  <= valid_d;
    end
  end

endmodule

// File: rtl/alp_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Small register queue: in up to two beats per cycle, out one unless stalled.
// ----------------------------------------------------------------------------
module alp_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  alp_pkg::alp_item_t item0_i,
  input  alp_pkg::alp_item_t item1_i,
  input  logic [1:0]         n_items_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output alp_pkg::alp_item_t item_o
);

  localparam int unsigned DEPTH = alp_pkg::OUTQ_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  alp_pkg::alp_item_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CNT_W-1:0] cnt_q, cnt_d, n_push;
  logic             pop;

  assign pop         = out_valid_o & ~out_stall_i;
  assign n_push      = push_i ? CNT_W'(n_items_i) : '0;
  assign wr_ptr_nx   = wr_ptr_q + PTR_W'(1);
  assign wr_ptr_d    = wr_ptr_q + PTR_W'(n_push);
  assign rd_ptr_d    = rd_ptr_q + PTR_W'(pop);
  assign cnt_d       = cnt_q + n_push - CNT_W'(pop);
  assign out_valid_o = (cnt_q != '0);
  // room for two beats is always kept before the next character is taken
  assign full_o      = (cnt_q > CNT_W'(DEPTH - 2));
  assign item_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && (n_items_i != 2'd0)) begin
      mem_q[wr_ptr_q] <= item0_i;
    end
    if (push_i && (n_items_i == 2'd2)) begin
      mem_q[wr_ptr_nx] <= item1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/audit_record_line_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audit record line parser core
// Splits an audit log line, one character per beat, into type, prefix and
// key/value parts, with a record-end beat per line.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | sink      | in_valid_i / in_stall_o   | action_i, ch_i
//  out     | source    | out_valid_o / out_stall_i | part_o .. last_o
//
//  One character beat is taken per cycle while in_stall_o is low; the parse
//  state and its result beats are registered at the same edge, the beats into
//  a four-entry queue. A character gives zero or one beat; an end of line
//  inside an open part gives two, which the queue hands out in order.
//  in_stall_o rises only when fewer than two queue slots are free, so a slow
//  sink backs up into the input without losing beats.
//  Reset (rst_ni low, asynchronous) returns the parser to header matching
//  and empties the queue.
//
module audit_record_line_parser_core #(
  parameter int unsigned TYPE_LEN_MAX   = alp_pkg::TYPE_LEN_MAX_DEF,
  parameter int unsigned PREFIX_LEN_MAX = alp_pkg::PREFIX_LEN_MAX_DEF,
  parameter int unsigned KEY_LEN_MAX    = alp_pkg::KEY_LEN_MAX_DEF,
  parameter int unsigned VALUE_LEN_MAX  = alp_pkg::VALUE_LEN_MAX_DEF,
  parameter int unsigned FIELDS_MAX     = alp_pkg::FIELDS_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // character input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] ch_i,
  // result output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] part_o,
  output logic       has_char_o,
  output logic [7:0] out_char_o,
  output logic       part_end_o,
  output logic       kept_o,
  output logic [5:0] field_index_o,
  output logic       record_valid_o,
  output logic [6:0] field_total_o,
  output logic       last_o
);

  alp_pkg::alp_item_t item0, item1, item_out;
  logic [1:0]         n_items;
  logic               accept;
  logic               q_full;

  // a character is consumed only when the queue can hold its worst case
  assign in_stall_o = q_full;
  assign accept     = in_valid_i & ~q_full;

  alp_parse #(
    .TYPE_LEN_MAX  (TYPE_LEN_MAX),
    .PREFIX_LEN_MAX(PREFIX_LEN_MAX),
    .KEY_LEN_MAX   (KEY_LEN_MAX),
    .VALUE_LEN_MAX (VALUE_LEN_MAX),
    .FIELDS_MAX    (FIELDS_MAX)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .action_i (action_i),
    .ch_i     (ch_i),
    .item0_o  (item0),
    .item1_o  (item1),
    .n_items_o(n_items)
  );

  alp_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .item0_i    (item0),
    .item1_i    (item1),
    .n_items_i  (n_items),
    .full_o     (q_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .item_o     (item_out)
  );

  assign part_o         = item_out.part;
  assign has_char_o     = item_out.has_char;
  assign out_char_o     = item_out.out_char;
  assign part_end_o     = item_out.part_end;
  assign kept_o         = item_out.kept;
  assign field_index_o  = item_out.field_index;
  assign record_valid_o = item_out.record_valid;
  assign field_total_o  = item_out.field_total;
  assign last_o         = item_out.last;

endmodule

// File: test/tb_audit_record_line_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audit record line parser core testbench
// Feeds audit log lines a character beat at a time, predicts the part beats
// from its own model of the parser and checks every result beat in order,
// with random gaps on the input, random stalls and one long hold-off on the
// output.
// ----------------------------------------------------------------------------
module tb_audit_record_line_parser_core;

  localparam int unsigned TYPE_LIM   = alp_pkg::TYPE_LEN_MAX_DEF;
  localparam int unsigned PREFIX_LIM = alp_pkg::PREFIX_LEN_MAX_DEF;
  localparam int unsigned KEY_LIM    = alp_pkg::KEY_LEN_MAX_DEF;
  localparam int unsigned VALUE_LIM  = alp_pkg::VALUE_LEN_MAX_DEF;
  localparam int unsigned FIELD_LIM  = alp_pkg::FIELDS_MAX_DEF;

  localparam int unsigned LINE_BEATS  = 1450;    // random character beats wanted
  localparam int unsigned HOLD_CYCLES = 400;     // long sink hold-off
  localparam int unsigned CYCLE_LIMIT = 300000;  // timeout, several times the slowest run

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] ch;
  } line_char_t;

  // clock and reset
  logic clk_i;
  logic rst_ni = 1'b0;

  // character channel
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       action_i   = ACT_CHAR;
  logic [7:0] ch_i       = 8'h00;

  // result channel
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] part_o;
  logic       has_char_o;
  logic [7:0] out_char_o;
  logic       part_end_o;
  logic       kept_o;
  logic [5:0] field_index_o;
  logic       record_valid_o;
  logic [6:0] field_total_o;
  logic       last_o;

  audit_record_line_parser_core #(
    .TYPE_LEN_MAX   (TYPE_LIM),
    .PREFIX_LEN_MAX (PREFIX_LIM),
    .KEY_LEN_MAX    (KEY_LIM),
    .VALUE_LEN_MAX  (VALUE_LIM),
    .FIELDS_MAX     (FIELD_LIM)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .ch_i           (ch_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .part_o         (part_o),
    .has_char_o     (has_char_o),
    .out_char_o     (out_char_o),
    .part_end_o     (part_end_o),
    .kept_o         (kept_o),
    .field_index_o  (field_index_o),
    .record_valid_o (record_valid_o),
    .field_total_o  (field_total_o),
    .last_o         (last_o)
  );

  // --------------------------------------------------------------------------
  // Parser model: its own copy of the line state, updated per accepted beat
  // --------------------------------------------------------------------------
  string hdr_word   = "type=";
  string msg_word   = "msg=";
  string seek_noise = "msg= mx";  // material that half-matches the msg= search

  alp_pkg::alp_mode_e pmode = alp_pkg::MODE_HDR;
  int unsigned mpos       = 0;     // position within type= or msg=
  int unsigned plen       = 0;     // characters kept in the open part
  logic [6:0]  nfields    = '0;    // complete key/value fields on this line
  logic        colon_seen = 1'b0;  // prefix colon found

  alp_pkg::alp_item_t expected_beats [$];
  line_char_t         line_chars [$];

  int unsigned errors  = 0;
  int unsigned fed     = 0;  // character beats accepted so far
  int unsigned counted = 0;  // generated beats that count towards the quota
  bit          counting = 1'b1;

  function automatic alp_pkg::alp_item_t mk_beat(alp_pkg::alp_part_e p, logic has,
                                                 logic [7:0] c, logic pend, logic kp,
                                                 logic [5:0] fi, logic rv,
                                                 logic [6:0] tot);
    alp_pkg::alp_item_t b;
    b.part         = p;
    b.has_char     = has;
    b.out_char     = has ? c : 8'h00;
    b.part_end     = pend;
    b.kept         = kp;
    b.field_index  = fi;
    b.record_valid = rv;
    b.field_total  = tot;
    b.last         = 1'b0;
    return b;
  endfunction

  // a part keeps at most limit - 1 characters
  function automatic bit take_room(int unsigned lim);
    if (plen < lim - 1) begin
      plen++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void parse_char(logic action, logic [7:0] c);
    alp_pkg::alp_item_t b [2];
    int                 n;
    logic [5:0]         fi;
    logic               has;
    n  = 0;
    fi = nfields[5:0];
    if (action == ACT_EOL || c == alp_pkg::CH_NUL) begin
      // an open part closes first, then the record end
      case (pmode)
        alp_pkg::MODE_TYPE: begin
          b[0] = mk_beat(alp_pkg::PART_TYPE, 1'b0, c, 1'b1, 1'b0, '0, 1'b0, '0);
          n = 1;
        end
        alp_pkg::MODE_PREFIX: begin
          b[0] = mk_beat(alp_pkg::PART_PREFIX, 1'b0, c, 1'b1, 1'b0, '0, 1'b0, '0);
          n = 1;
        end
        alp_pkg::MODE_KEY: begin
          b[0] = mk_beat(alp_pkg::PART_KEY, 1'b0, c, 1'b1, 1'b0, fi, 1'b0, '0);
          n = 1;
        end
        alp_pkg::MODE_VALUE: begin
          // a value cut by the line end still counts as a field
          b[0] = mk_beat(alp_pkg::PART_VALUE, 1'b0, c, 1'b1, 1'b1, fi, 1'b0, '0);
          n = 1;
          nfields = nfields + 7'd1;
        end
        default: ;
      endcase
      b[n] = mk_beat(alp_pkg::PART_REC_END, 1'b0, c, 1'b0, 1'b0, '0, colon_seen,
                     nfields);
      n++;
      pmode      = alp_pkg::MODE_HDR;
      mpos       = 0;
      plen       = 0;
      nfields    = '0;
      colon_seen = 1'b0;
    end else begin
      case (pmode)
        alp_pkg::MODE_HDR: begin
          if (mpos < 5 && c == hdr_word[mpos]) begin
            mpos++;
            if (mpos == 5) begin
              pmode = alp_pkg::MODE_TYPE;
              mpos  = 0;
              plen  = 0;
            end
          end else begin
            pmode = alp_pkg::MODE_IGNORE;
            mpos  = 0;
          end
        end
        alp_pkg::MODE_TYPE: begin
          if (c == alp_pkg::CH_SPACE) begin
            b[0] = mk_beat(alp_pkg::PART_TYPE, 1'b0, c, 1'b1, 1'b1, '0, 1'b0, '0);
            n = 1;
            pmode = alp_pkg::MODE_SEEK;
            mpos  = 0;
            plen  = 0;
          end else if (take_room(TYPE_LIM)) begin
            b[0] = mk_beat(alp_pkg::PART_TYPE, 1'b1, c, 1'b0, 1'b0, '0, 1'b0, '0);
            n = 1;
          end
        end
        alp_pkg::MODE_SEEK: begin
          if (mpos < 4 && c == msg_word[mpos]) begin
            mpos++;
            if (mpos == 4) begin
              pmode = alp_pkg::MODE_PREFIX;
              mpos  = 0;
              plen  = 0;
            end
          end else begin
            mpos = (c == alp_pkg::CH_M) ? 1 : 0;
          end
        end
        alp_pkg::MODE_PREFIX: begin
          has = take_room(PREFIX_LIM);
          if (c == alp_pkg::CH_COLON) begin
            // the colon rides on the closing beat only if there is room
            b[0] = mk_beat(alp_pkg::PART_PREFIX, has, c, 1'b1, 1'b1, '0, 1'b0, '0);
            n = 1;
            colon_seen = 1'b1;
            plen  = 0;
            pmode = (nfields >= FIELD_LIM) ? alp_pkg::MODE_DONE : alp_pkg::MODE_KSKIP;
          end else if (has) begin
            b[0] = mk_beat(alp_pkg::PART_PREFIX, 1'b1, c, 1'b0, 1'b0, '0, 1'b0, '0);
            n = 1;
          end
        end
        alp_pkg::MODE_KSKIP: begin
          if (c != alp_pkg::CH_SPACE) begin
            plen = 0;
            if (c == alp_pkg::CH_EQUAL) begin
              b[0] = mk_beat(alp_pkg::PART_KEY, 1'b0, c, 1'b1, 1'b1, fi, 1'b0, '0);
              n = 1;
              pmode = alp_pkg::MODE_VALUE;
            end else begin
              if (take_room(KEY_LIM)) begin
                b[0] = mk_beat(alp_pkg::PART_KEY, 1'b1, c, 1'b0, 1'b0, fi, 1'b0, '0);
                n = 1;
              end
              pmode = alp_pkg::MODE_KEY;
            end
          end
        end
        alp_pkg::MODE_KEY: begin
          if (c == alp_pkg::CH_EQUAL) begin
            b[0] = mk_beat(alp_pkg::PART_KEY, 1'b0, c, 1'b1, 1'b1, fi, 1'b0, '0);
            n = 1;
            pmode = alp_pkg::MODE_VALUE;
            plen  = 0;
          end else if (take_room(KEY_LIM)) begin
            b[0] = mk_beat(alp_pkg::PART_KEY, 1'b1, c, 1'b0, 1'b0, fi, 1'b0, '0);
            n = 1;
          end
        end
        alp_pkg::MODE_VALUE: begin
          if (c == alp_pkg::CH_SPACE) begin
            b[0] = mk_beat(alp_pkg::PART_VALUE, 1'b0, c, 1'b1, 1'b1, fi, 1'b0, '0);
            n = 1;
            nfields = nfields + 7'd1;
            plen  = 0;
            pmode = (nfields >= FIELD_LIM) ? alp_pkg::MODE_DONE : alp_pkg::MODE_KSKIP;
          end else if (take_room(VALUE_LIM)) begin
            b[0] = mk_beat(alp_pkg::PART_VALUE, 1'b1, c, 1'b0, 1'b0, fi, 1'b0, '0);
            n = 1;
          end
        end
        default: ;  // ignored line or field limit reached
      endcase
    end
    if (n > 0) b[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_beats.push_back(b[k]);
  endfunction

  // --------------------------------------------------------------------------
  // Line generation
  // --------------------------------------------------------------------------
  task automatic put(logic a, logic [7:0] c);
    line_char_t e;
    e.action = a;
    e.ch     = c;
    line_chars.push_back(e);
    if (counting) counted++;
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put(ACT_CHAR, s[i]);
  endtask

  // end of line either by action or by a NUL character
  task automatic put_eol();
    if ($urandom_range(0, 2) == 0) put(ACT_CHAR, alp_pkg::CH_NUL);
    else put(ACT_EOL, 8'($urandom_range(0, 255)));
  endtask

  // mostly lower-case letters, now and then any non-NUL byte
  function automatic logic [7:0] rand_char(logic [7:0] avoid);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                      : 8'($urandom_range(97, 122));
    end while (c == avoid);
    return c;
  endfunction

  // short most of the time, now and then straddling the truncation limit
  function automatic int pick_len(int short_max, int long_lo, int long_hi, int odds);
    if ($urandom_range(0, odds - 1) == 0) return $urandom_range(long_lo, long_hi);
    return $urandom_range(0, short_max);
  endfunction

  task automatic gen_line();
    int unsigned brk, len, nf;
    bit          packed_fields;
    // plain noise: the parser ignores it, so it does not count
    if ($urandom_range(0, 99) < 8) begin
      counting = 1'b0;
      len = $urandom_range(0, 8);
      for (int k = 0; k < len; k++) put(ACT_CHAR, 8'($urandom_range(1, 255)));
      put_eol();
      counting = 1'b1;
      return;
    end
    // header, now and then with one character spoiled
    brk = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4) : 5;
    for (int k = 0; k < 5; k++)
      put(ACT_CHAR, (k == brk) ? rand_char(hdr_word[k]) : 8'(hdr_word[k]));
    len = pick_len(5, 28, 36, 8);
    for (int k = 0; k < len; k++) put(ACT_CHAR, rand_char(alp_pkg::CH_SPACE));
    if ($urandom_range(0, 19) == 0) begin
      put_eol();  // line ends inside the type
      return;
    end
    put(ACT_CHAR, alp_pkg::CH_SPACE);
    len = $urandom_range(0, 4);
    for (int k = 0; k < len; k++) put(ACT_CHAR, seek_noise[$urandom_range(0, 6)]);
    if ($urandom_range(0, 19) == 0) begin
      put_eol();  // no msg= on this line
      return;
    end
    put_str(msg_word);
    len = pick_len(6, 60, 68, 8);
    for (int k = 0; k < len; k++) put(ACT_CHAR, rand_char(alp_pkg::CH_COLON));
    if ($urandom_range(0, 19) == 0) begin
      put_eol();  // line ends inside the prefix
      return;
    end
    put(ACT_CHAR, alp_pkg::CH_COLON);
    // now and then enough tiny fields to come near or run past the field limit
    packed_fields = ($urandom_range(0, 11) == 0);
    nf = packed_fields ? $urandom_range(FIELD_LIM - 2, FIELD_LIM + 2)
                       : $urandom_range(0, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) put(ACT_CHAR, alp_pkg::CH_SPACE);
      if ($urandom_range(0, 3) == 0) put(ACT_CHAR, alp_pkg::CH_SPACE);
      len = packed_fields ? $urandom_range(0, 2) : pick_len(5, 60, 68, 15);
      for (int k = 0; k < len; k++)
        put(ACT_CHAR, (k > 0 && $urandom_range(0, 7) == 0) ? alp_pkg::CH_SPACE
                                                           : rand_char(alp_pkg::CH_EQUAL));
      if ($urandom_range(0, 24) == 0) begin
        put_eol();  // line ends inside a key
        return;
      end
      put(ACT_CHAR, alp_pkg::CH_EQUAL);
      if (packed_fields) len = $urandom_range(0, 2);
      else if ($urandom_range(0, 39) == 0) len = $urandom_range(VALUE_LIM - 6, VALUE_LIM + 4);
      else len = $urandom_range(0, 5);
      for (int k = 0; k < len; k++) put(ACT_CHAR, rand_char(alp_pkg::CH_SPACE));
    end
    if ($urandom_range(0, 5) == 0) put(ACT_CHAR, alp_pkg::CH_SPACE);
    put_eol();
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Character driver: pops the pending queue, random gap after each beat,
  // now and then a burst with no gaps at all
  // --------------------------------------------------------------------------
  int unsigned src_wait  = 0;
  bit          src_burst = 1'b0;
  line_char_t  pending;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        parse_char(action_i, ch_i);
        fed++;
        if ($urandom_range(0, 63) == 0) src_burst = ~src_burst;
        src_wait = src_burst ? 0 : $urandom_range(0, 9);
        if (src_wait == 0 && line_chars.size() > 0) begin
          // back to back: valid stays high, payload moves on
          pending = line_chars.pop_front();
          action_i <= pending.action;
          ch_i     <= pending.ch;
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (line_chars.size() > 0) begin
          pending = line_chars.pop_front();
          action_i   <= pending.action;
          ch_i       <= pending.ch;
          in_valid_i <= 1'b1;
        end
      end
      // offered but stalled: hold the beat as it is
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each accepted beat against the oldest prediction
  // and draws the stall before the next one
  // --------------------------------------------------------------------------
  int unsigned        sink_wait  = 0;
  bit                 sink_burst = 1'b0;
  logic               long_hold  = 1'b0;
  alp_pkg::alp_item_t want;

  task automatic check_field(string what, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, %s %0d %0d",
                   $time, "actual part and char", part_o, out_char_o);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          check_field("part", want.part, part_o);
          check_field("has_char", want.has_char, has_char_o);
          check_field("out_char", want.out_char, out_char_o);
          check_field("part_end", want.part_end, part_end_o);
          check_field("kept", want.kept, kept_o);
          check_field("field_index", want.field_index, field_index_o);
          check_field("record_valid", want.record_valid, record_valid_o);
          check_field("field_total", want.field_total, field_total_o);
          check_field("last", want.last, last_o);
        end
        if ($urandom_range(0, 63) == 0) sink_burst = ~sink_burst;
        sink_wait = sink_burst ? 0 : $urandom_range(0, 9);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      out_stall_i <= long_hold || (sink_wait > 0);
    end
  end

  // One long hold-off part way through: the sender keeps offering, the
  // result queue fills and the core has to stall its input
  initial begin
    while (fed < 300) @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Timeout
  // --------------------------------------------------------------------------
  int unsigned cycles = 0;

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_audit_record_line_parser_core: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    // directed: empty type, bare colon prefix, empty key, 0xff value cut by
    // the line end action
    put_str("type= msg=:=");
    put(ACT_CHAR, 8'hff);
    put(ACT_EOL, 8'hff);
    // ignored line closed by NUL
    put(ACT_CHAR, 8'h78);
    put(ACT_CHAR, alp_pkg::CH_NUL);
    // line end inside the type
    put_str("type=a");
    put(ACT_EOL, 8'h00);

    while (counted < LINE_BEATS) gen_line();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all beats offered and accepted, every prediction checked
    while (line_chars.size() != 0 || in_valid_i || expected_beats.size() != 0)
      @(posedge clk_i);
    // then wait on to catch stray beats
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_audit_record_line_parser_core: clean");
    end else begin
      $display("tb_audit_record_line_parser_core: errors");
    end
    $finish;
  end

endmodule
